### rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam logic [15:0] QUANTUM_RESET = 16'd100;

  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_SPAWN  = 3'd1;
  localparam logic [2:0] FN_TERM   = 3'd2;
  localparam logic [2:0] FN_BLOCK  = 3'd3;
  localparam logic [2:0] FN_RESUME = 3'd4;
  localparam logic [2:0] FN_JOIN   = 3'd5;
  localparam logic [2:0] FN_QUERY  = 3'd6;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture a new command and evaluate it
    logic walk_start; // clear walk index
    logic walk_step;  // process one slot of a release walk
    logic pop_step;   // pop one queue head for a switch
    logic finish_sw;  // complete a switch
    logic clear_step; // clear one slot (terminate of slot 0)
  } rrts_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_release; // command wants a release walk before its action
    logic need_switch;  // command ends in a switch
    logic need_clear;   // command clears everything
    logic walk_last;    // walk index at last slot
    logic pop_done;     // pop phase finished
  } rrts_stat_t;

endpackage

### rtl/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: slot state, ready queue, wait matrix, counters.
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF,
  parameter int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  parameter int CW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic [2:0]          func,
  input  logic [5:0]          thread_id,
  input  rrts_pkg::rrts_cmd_t cmd,
  output rrts_pkg::rrts_stat_t stat,
  output logic                o_status,
  output logic [31:0]         o_value,
  output logic                o_run_valid,
  output logic [3:0]          o_run_id,
  output logic                o_switched,
  output logic [31:0]         o_total
);

  logic [15:0] quantum_r;
  logic [SLOT_COUNT-1:0] used_r;
  logic [1:0]  state_r [SLOT_COUNT];
  logic [31:0] quanta_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] wm_r [SLOT_COUNT];
  logic [CW-1:0] wc_r [SLOT_COUNT];
  logic [IW-1:0] q_r [SLOT_COUNT];
  logic [CW-1:0] qlen_r;
  logic [SLOT_COUNT-1:0] inq_r;   // slot is in the queue
  logic cur_v_r;
  logic [IW-1:0] cur_r;
  logic [31:0] total_r;
  logic [15:0] tick_r;
  logic [IW-1:0] widx_r;
  logic [IW-1:0] rel_r;           // slot whose waiters are released
  logic rel_do_r, sw_do_r, clr_do_r, found_r;
  logic status_r, switched_r;
  logic [31:0] value_r;
  logic [IW-1:0] nxt_r;

  logic ok;
  logic [IW-1:0] t;
  logic [IW-1:0] freei;
  logic free_found;
  logic [15:0] tick_inc;
  logic [15:0] qeff;

  assign t  = thread_id[IW-1:0];
  assign ok = ({1'b0, thread_id} < 7'(SLOT_COUNT)) && used_r[t];
  assign tick_inc = tick_r + 16'd1;
  assign qeff = (quantum_r == 16'd0) ? 16'd1 : quantum_r;

  always_comb begin
    freei = '0;
    free_found = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        freei = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign stat.need_release = rel_do_r;
  assign stat.need_switch  = sw_do_r;
  assign stat.need_clear   = clr_do_r;
  assign stat.walk_last    = (widx_r == IW'(SLOT_COUNT - 1));
  assign stat.pop_done     = found_r || (qlen_r == '0);

  assign o_status    = status_r;
  assign o_value     = value_r;
  assign o_run_valid = cur_v_r;
  assign o_run_id    = cur_v_r ? 4'(cur_r) : 4'd0;
  assign o_switched  = switched_r;
  assign o_total     = total_r;

  // queue removal by id: shift entries at and after the match down one
  function automatic void q_remove(input logic [IW-1:0] id,
                                   inout logic [IW-1:0] q [SLOT_COUNT],
                                   inout logic [CW-1:0] len,
                                   inout logic [SLOT_COUNT-1:0] inq);
    logic hit;
    hit = 1'b0;
    if (inq[id]) begin
      for (int k = 0; k < SLOT_COUNT - 1; k++) begin
        if (CW'(k) < len && q[k] == id) hit = 1'b1;
        if (hit) q[k] = q[k+1];
      end
      len = len - CW'(1);
      inq[id] = 1'b0;
    end
  endfunction

  always_ff @(posedge clk) begin
    logic [IW-1:0] qn [SLOT_COUNT];
    logic [CW-1:0] ln;
    logic [SLOT_COUNT-1:0] iq;
    logic [IW-1:0] h;
    qn = q_r;
    ln = qlen_r;
    iq = inq_r;
    h  = q_r[0];
    if (!rst_n) begin
      quantum_r <= rrts_pkg::QUANTUM_RESET;
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
    if (!rst_n) begin
      used_r <= '0;
      qlen_r <= '0;
      inq_r <= '0;
      cur_v_r <= 1'b0;
      cur_r <= '0;
      total_r <= '0;
      tick_r <= '0;
      widx_r <= '0;
      rel_do_r <= 1'b0;
      sw_do_r <= 1'b0;
      clr_do_r <= 1'b0;
      found_r <= 1'b0;
      status_r <= 1'b0;
      switched_r <= 1'b0;
      value_r <= '0;
      rel_r <= '0;
      nxt_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        state_r[i] <= rrts_pkg::ST_READY;
        quanta_r[i] <= '0;
        wm_r[i] <= '0;
        wc_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        logic st_n, swd_n, reld_n, clr_n;
        logic [31:0] val_n;
        logic [IW-1:0] rel_n;
        st_n = 1'b0;
        swd_n = 1'b0;
        reld_n = 1'b0;
        clr_n = 1'b0;
        val_n = '0;
        rel_n = cur_r;
        unique case (func)
          rrts_pkg::FN_TICK: begin
            if (cur_v_r) begin
              tick_r <= tick_inc;
              if (tick_inc >= qeff) begin
                swd_n = 1'b1;
                reld_n = 1'b1;
              end
            end
          end
          rrts_pkg::FN_SPAWN: begin
            if (!free_found) st_n = 1'b1;
            else begin
              used_r[freei] <= 1'b1;
              // slot 0 starts running at once
              state_r[freei] <= (freei == '0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_READY;
              quanta_r[freei] <= '0;
              wc_r[freei] <= '0;
              wm_r[freei] <= '0;
              val_n = 32'(freei);
              if (!iq[freei]) begin
                qn[ln[IW-1:0]] = freei;
                ln = ln + CW'(1);
                iq[freei] = 1'b1;
              end
              if (freei == '0) begin
                cur_v_r <= 1'b1;
                cur_r <= '0;
                rel_n = '0;
                swd_n = 1'b1;
                reld_n = 1'b1;
              end
            end
          end
          rrts_pkg::FN_TERM: begin
            if (!ok) st_n = 1'b1;
            else if (t == '0) clr_n = 1'b1;
            else begin
              if (cur_v_r && cur_r == t) begin
                cur_v_r <= 1'b0;
                cur_r <= '0;
                swd_n = 1'b1;
              end
              used_r[t] <= 1'b0;
              rel_n = t;
              reld_n = 1'b1;
            end
          end
          rrts_pkg::FN_BLOCK: begin
            if (!ok || t == '0) st_n = 1'b1;
            else if (state_r[t] != rrts_pkg::ST_BLOCKED) begin
              state_r[t] <= rrts_pkg::ST_BLOCKED;
              q_remove(t, qn, ln, iq);
              if (cur_v_r && cur_r == t) begin
                swd_n = 1'b1;
                reld_n = 1'b1;
              end
            end
          end
          rrts_pkg::FN_RESUME: begin
            if (!ok) st_n = 1'b1;
            else begin
              state_r[t] <= rrts_pkg::ST_READY;
              if (wc_r[t] == '0 && !iq[t]) begin
                qn[ln[IW-1:0]] = t;
                ln = ln + CW'(1);
                iq[t] = 1'b1;
              end
            end
          end
          rrts_pkg::FN_JOIN: begin
            if (!ok || !cur_v_r || cur_r == '0) st_n = 1'b1;
            else begin
              if (!wm_r[t][cur_r]) begin
                wm_r[t][cur_r] <= 1'b1;
                wc_r[cur_r] <= wc_r[cur_r] + CW'(1);
              end
              swd_n = 1'b1;
              reld_n = 1'b1;
            end
          end
          rrts_pkg::FN_QUERY: begin
            if (!ok) st_n = 1'b1;
            else val_n = quanta_r[t];
          end
          default: st_n = 1'b1;
        endcase
        status_r <= st_n;
        value_r <= val_n;
        switched_r <= 1'b0;
        rel_do_r <= reld_n;
        sw_do_r <= swd_n;
        clr_do_r <= clr_n;
        found_r <= 1'b0;
        rel_r <= rel_n;
      end

      if (cmd.walk_start) widx_r <= '0;

      // one slot of the release walk on rel_r
      if (cmd.walk_step) begin
        logic [CW-1:0] wci;
        logic [SLOT_COUNT-1:0] wmt;
        wmt = wm_r[rel_r];
        wci = wc_r[widx_r];
        if (wmt[widx_r] && wci != '0) wci = wci - CW'(1);
        wmt[widx_r] = 1'b0;
        if (used_r[widx_r] && wci == '0 && state_r[widx_r] != rrts_pkg::ST_BLOCKED &&
            !iq[widx_r] && ln < CW'(SLOT_COUNT)) begin
          qn[ln[IW-1:0]] = widx_r;
          ln = ln + CW'(1);
          iq[widx_r] = 1'b1;
        end
        // a released slot that is gone drops every wait recorded on it
        if (!used_r[rel_r]) begin
          if (widx_r != rel_r) begin
            wm_r[widx_r][rel_r] <= 1'b0;
            wc_r[rel_r] <= '0;
          end else begin
            wci = '0;
          end
        end
        wm_r[rel_r] <= wmt;
        wc_r[widx_r] <= wci;
        widx_r <= widx_r + IW'(1);
        // a terminated slot leaves the queue once the walk is over
        if (widx_r == IW'(SLOT_COUNT - 1) && !used_r[rel_r]) begin
          q_remove(rel_r, qn, ln, iq);
          state_r[rel_r] <= rrts_pkg::ST_READY;
          quanta_r[rel_r] <= '0;
        end
      end

      if (cmd.pop_step && !found_r && ln != '0) begin
        for (int k = 0; k < SLOT_COUNT - 1; k++) qn[k] = qn[k+1];
        ln = ln - CW'(1);
        iq[h] = 1'b0;
        if (state_r[h] != rrts_pkg::ST_BLOCKED) begin
          found_r <= 1'b1;
          nxt_r <= h;
        end
      end

      if (cmd.finish_sw) begin
        // old thread goes back to ready unless it is blocked or is picked again
        if (cur_v_r && state_r[cur_r] != rrts_pkg::ST_BLOCKED &&
            !(found_r && nxt_r == cur_r))
          state_r[cur_r] <= rrts_pkg::ST_READY;
        if (!found_r) begin
          cur_v_r <= 1'b0;
          cur_r <= '0;
        end else begin
          state_r[nxt_r] <= rrts_pkg::ST_RUNNING;
          quanta_r[nxt_r] <= quanta_r[nxt_r] + 32'd1;
          total_r <= total_r + 32'd1;
          cur_r <= nxt_r;
          cur_v_r <= 1'b1;
          tick_r <= '0;
          switched_r <= 1'b1;
        end
      end

      if (cmd.clear_step) begin
        used_r[widx_r] <= 1'b0;
        state_r[widx_r] <= rrts_pkg::ST_READY;
        quanta_r[widx_r] <= '0;
        wm_r[widx_r] <= '0;
        wc_r[widx_r] <= '0;
        widx_r <= widx_r + IW'(1);
        if (widx_r == IW'(SLOT_COUNT - 1)) begin
          ln = '0;
          iq = '0;
          cur_v_r <= 1'b0;
          cur_r <= '0;
          total_r <= '0;
          tick_r <= '0;
        end
      end

      q_r <= qn;
      qlen_r <= ln;
      inq_r <= iq;
    end
  end

endmodule

### rtl/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Scheduler sequencer: accept, release walk, queue pop, clear, respond.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  rrts_pkg::rrts_stat_t stat,
  output rrts_pkg::rrts_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.walk_start = 1'b1;
        priority if (stat.need_clear) state_nxt = S_CLR;
        else if (stat.need_release) state_nxt = S_WALK;
        else state_nxt = S_OUT;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_nxt = stat.need_switch ? S_POP : S_OUT;
      end
      S_POP: begin
        cmd.pop_step = 1'b1;
        if (stat.pop_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_sw = 1'b1;
        state_nxt = S_OUT;
      end
      S_CLR: begin
        cmd.clear_step = 1'b1;
        if (stat.walk_last) state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### rtl/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Round-robin scheduler with block, resume and join over a pool of slots.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// in_     | in  | tdata[2:0] func, tdata[8:3] thread_id
// out_    | out | tdata: status, value, running_valid, running_id, switched,
//         |     | total_quanta (low bit up), 71 bits in 72
// cfg_    | in  | quantum_length, 16 bits
//
// One command at a time: accept, decode and result run from one accept to
// the next. A release walk visits every slot, one slot per cycle; a switch
// adds a pop phase, which pops queue heads until a non-blocked one is found
// or the queue is empty, and a finish step. Terminating slot 0 clears one
// slot per cycle. Reset is synchronous; the result holds in the output
// register until out_tready, no new command is taken meanwhile.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // func[2:0], thread_id[8:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, value, running_valid, running_id,
                                  // switched, total_quanta
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  rrts_pkg::rrts_cmd_t  cmd;
  rrts_pkg::rrts_stat_t stat;
  logic        st, rv, sw;
  logic [31:0] val, tot;
  logic [3:0]  rid;

  rrts_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .cmd
  );

  rrts_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .func(in_tdata[2:0]), .thread_id(in_tdata[8:3]),
    .cmd, .stat,
    .o_status(st), .o_value(val), .o_run_valid(rv), .o_run_id(rid),
    .o_switched(sw), .o_total(tot)
  );

  assign out_tdata = {1'b0, tot, sw, rid, rv, val, st};

endmodule
